// ===== src/off_axis_portal_frustum_top_assert.svh =====
// ---------------------------------------------------------------------------
// off_axis_portal_frustum_top_assert
// assertion macros shared by the frustum block, clocked on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef OFF_AXIS_PORTAL_FRUSTUM_TOP_ASSERT_SVH
`define OFF_AXIS_PORTAL_FRUSTUM_TOP_ASSERT_SVH

// same-cycle implication
`define OFPF_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication
`define OFPF_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// ===== src/ofpf_pkg.sv =====
// ---------------------------------------------------------------------------
// ofpf_pkg
// widths, constants, register codes and helpers of the portal frustum block
// ---------------------------------------------------------------------------
package ofpf_pkg;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned SIZE_W     = 24;
	localparam int unsigned CFG_W      = 2 * SIZE_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DIFF_W     = COORD_W + 1;
	localparam int unsigned MAT_W      = 32;
	localparam int unsigned PROD_W     = MAT_W + DIFF_W;
	localparam int unsigned ACC_W      = 64;
	localparam int unsigned SQ_W       = 2 * COORD_W;
	localparam int unsigned N2_W       = 61;
	localparam int unsigned N28_SH     = 28;
	localparam int unsigned N28_W      = 29;
	localparam int unsigned QUO_W      = 32;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned TSUM_W     = 35;
	localparam int unsigned TNUM_W     = TSUM_W + FRAC_W;
	localparam int unsigned TDEN_W     = COORD_W + 1;
	localparam int unsigned SETTLE_CYC = 3;
	localparam int unsigned SETTLE_W   = $clog2(SETTLE_CYC + 1);

	// unit norm and its tolerance in Q.56
	localparam logic [N2_W-1:0] NORM_ONE = 61'd72057594037927936;
	localparam logic [N2_W-1:0] NORM_TOL = 61'd72057594037927;
	// 0.10 in Q16.16
	localparam logic signed [COORD_W-1:0] DEPTH_MIN = 32'sd6554;
	localparam logic [COORD_W-1:0] QUAT_W_RST = 32'h4000_0000;
	localparam logic [CFG_W-1:0] SIZE_RST = 48'd769654829875;
	localparam logic [QUO_W-1:0] QUO_NEG_LIM = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X,
		REG_POS_Y,
		REG_POS_Z,
		REG_QUAT_X,
		REG_QUAT_Y,
		REG_QUAT_Z,
		REG_QUAT_W,
		REG_SIZE
	} cfg_reg_t;

	// settled configuration as seen by the item pipeline
	typedef struct packed {
		logic [2:0][COORD_W-1:0]    pos;
		logic [2:0][2:0][MAT_W-1:0] m;
		logic [N28_W-1:0]           n28;
		logic [SIZE_W-1:0]          wsz;
		logic [SIZE_W-1:0]          hsz;
		logic                       ok;
	} cfg_view_t;

	// signed quotient from magnitude fits in 32 bits
	function automatic logic quo_fits(input logic [QUO_W-1:0] q, input logic neg,
		input logic ovf);
		quo_fits = !ovf && (neg ? (!q[QUO_W-1] || q == QUO_NEG_LIM) : !q[QUO_W-1]);
	endfunction

	// apply sign to quotient magnitude
	function automatic logic [QUO_W-1:0] quo_apply(input logic [QUO_W-1:0] q,
		input logic neg);
		quo_apply = neg ? -q : q;
	endfunction

endpackage

// ===== src/ofpf_cfg.sv =====
// ---------------------------------------------------------------------------
// ofpf_cfg
// configuration registers and the derived rotation matrix and norm check
// ---------------------------------------------------------------------------
module ofpf_cfg import ofpf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_view_t            view,
	output logic                 settled
);

	localparam int unsigned EW = MAT_W + 2;

	logic [2:0][COORD_W-1:0] pos_q;
	logic [3:0][COORD_W-1:0] quat_q;
	logic [CFG_W-1:0]        size_q;
	logic [SETTLE_W-1:0]     settle_q;

	logic signed [COORD_W-1:0] qx, qy, qz, qw;
	logic signed [SQ_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [EW-1:0] pxx, pyy, pzz, pww, pxy, pxz, pyz, pwx, pwy, pwz;
	logic [2:0][2:0][EW-1:0]    ent;
	logic [2:0][2:0][MAT_W-1:0] m_s2, m_s3;
	logic [N2_W-1:0]            n2_s2;
	logic [N28_W-1:0]           n28_s3;
	logic                       ok_s3;

	function automatic logic signed [EW-1:0] hi_part(input logic [SQ_W-1:0] v);
		hi_part = EW'($signed(v[SQ_W-1:SQ_W-MAT_W]));
	endfunction

	// register writes and settle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			quat_q    <= {QUAT_W_RST, {(3*COORD_W){1'b0}}};
			size_q    <= SIZE_RST;
			settle_q  <= SETTLE_W'(SETTLE_CYC);
		end else if (cfg_we) begin
			settle_q <= SETTLE_W'(SETTLE_CYC);
			case (cfg_reg_t'(cfg_idx))
				REG_POS_X:  pos_q[0]  <= cfg_wdata[COORD_W-1:0];
				REG_POS_Y:  pos_q[1]  <= cfg_wdata[COORD_W-1:0];
				REG_POS_Z:  pos_q[2]  <= cfg_wdata[COORD_W-1:0];
				REG_QUAT_X: quat_q[0] <= cfg_wdata[COORD_W-1:0];
				REG_QUAT_Y: quat_q[1] <= cfg_wdata[COORD_W-1:0];
				REG_QUAT_Z: quat_q[2] <= cfg_wdata[COORD_W-1:0];
				REG_QUAT_W: quat_q[3] <= cfg_wdata[COORD_W-1:0];
				REG_SIZE:   size_q    <= cfg_wdata;
				default: ;
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign qx = $signed(quat_q[0]);
	assign qy = $signed(quat_q[1]);
	assign qz = $signed(quat_q[2]);
	assign qw = $signed(quat_q[3]);

	// quaternion products
	always_ff @(posedge clk) begin
		xx_s1 <= SQ_W'(qx) * SQ_W'(qx);
		yy_s1 <= SQ_W'(qy) * SQ_W'(qy);
		zz_s1 <= SQ_W'(qz) * SQ_W'(qz);
		ww_s1 <= SQ_W'(qw) * SQ_W'(qw);
		xy_s1 <= SQ_W'(qx) * SQ_W'(qy);
		xz_s1 <= SQ_W'(qx) * SQ_W'(qz);
		yz_s1 <= SQ_W'(qy) * SQ_W'(qz);
		wx_s1 <= SQ_W'(qw) * SQ_W'(qx);
		wy_s1 <= SQ_W'(qw) * SQ_W'(qy);
		wz_s1 <= SQ_W'(qw) * SQ_W'(qz);
	end

	// floor of each product in Q.28
	always_comb begin
		pxx = hi_part(xx_s1);
		pyy = hi_part(yy_s1);
		pzz = hi_part(zz_s1);
		pww = hi_part(ww_s1);
		pxy = hi_part(xy_s1);
		pxz = hi_part(xz_s1);
		pyz = hi_part(yz_s1);
		pwx = hi_part(wx_s1);
		pwy = hi_part(wy_s1);
		pwz = hi_part(wz_s1);
		// transposed rotation, row r gives eye component r
		ent[0][0] = pww + pxx - pyy - pzz;
		ent[0][1] = (pxy + pwz) <<< 1;
		ent[0][2] = (pxz - pwy) <<< 1;
		ent[1][0] = (pxy - pwz) <<< 1;
		ent[1][1] = pww - pxx + pyy - pzz;
		ent[1][2] = (pyz + pwx) <<< 1;
		ent[2][0] = (pxz + pwy) <<< 1;
		ent[2][1] = (pyz - pwx) <<< 1;
		ent[2][2] = pww - pxx - pyy + pzz;
	end

	// matrix and squared norm
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				m_s2[r][c] <= ent[r][c][MAT_W-1:0];
			end
		end
		n2_s2 <= N2_W'(xx_s1[SQ_W-2:4]) + N2_W'(yy_s1[SQ_W-2:4]) +
			N2_W'(zz_s1[SQ_W-2:4]) + N2_W'(ww_s1[SQ_W-2:4]);
	end

	// norm tolerance check and divisor
	always_ff @(posedge clk) begin
		m_s3   <= m_s2;
		n28_s3 <= n2_s2[N28_SH +: N28_W];
		ok_s3  <= (n2_s2 >= NORM_ONE - NORM_TOL) && (n2_s2 <= NORM_ONE + NORM_TOL);
	end

	always_comb begin
		view.pos = pos_q;
		view.m   = m_s3;
		view.n28 = n28_s3;
		view.wsz = size_q[SIZE_W-1:0];
		view.hsz = size_q[CFG_W-1:SIZE_W];
		view.ok  = ok_s3 && (size_q[SIZE_W-1:0] != '0) && (size_q[CFG_W-1:SIZE_W] != '0);
	end

	assign settled = (settle_q == '0);

endmodule

// ===== src/ofpf_rot.sv =====
// ---------------------------------------------------------------------------
// ofpf_rot
// eye offset from portal origin and rotation into portal space, four stages
// ---------------------------------------------------------------------------
module ofpf_rot import ofpf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ce,
	input  logic                    in_valid,
	input  logic [2:0][COORD_W-1:0] eye,
	input  cfg_view_t               view,
	output logic                    out_valid,
	output logic [2:0][ACC_W-1:0]   out_mag,
	output logic [2:0]              out_neg,
	output logic                    out_ok
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic ok_s1, ok_s2, ok_s3, ok_s4;
	logic [2:0][DIFF_W-1:0]       d_s1;
	logic [2:0][2:0][PROD_W-1:0]  prod_s2;
	logic [2:0][ACC_W-1:0]        acc_s3;
	logic [2:0][ACC_W-1:0]        mag_s4;
	logic [2:0]                   neg_s4;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// difference, products, row sums, magnitude
	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s1 <= view.ok;
			ok_s2 <= ok_s1;
			ok_s3 <= ok_s2;
			ok_s4 <= ok_s3;
			for (int c = 0; c < 3; c++) begin
				d_s1[c] <= DIFF_W'($signed(eye[c])) - DIFF_W'($signed(view.pos[c]));
			end
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= PROD_W'($signed(view.m[r][c])) *
						PROD_W'($signed(d_s1[c]));
				end
			end
			for (int r = 0; r < 3; r++) begin
				acc_s3[r] <= ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1]) +
					ACC_W'(prod_s2[r][2]);
			end
			for (int r = 0; r < 3; r++) begin
				neg_s4[r] <= acc_s3[r][ACC_W-1];
				mag_s4[r] <= acc_s3[r][ACC_W-1] ? -acc_s3[r] : acc_s3[r];
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_mag   = mag_s4;
	assign out_neg   = neg_s4;
	assign out_ok    = ok_s4;

endmodule

// ===== src/ofpf_div.sv =====
// ---------------------------------------------------------------------------
// ofpf_div
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ---------------------------------------------------------------------------
module ofpf_div import ofpf_pkg::*; #(
	parameter int unsigned LANES = 3,
	parameter int unsigned NUM_W = 64,
	parameter int unsigned DEN_W = 29,
	parameter int unsigned TAG_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0]            in_den,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [LANES-1:0][QUO_W-1:0] out_quo,
	output logic [LANES-1:0]            out_ovf,
	output logic [TAG_W-1:0]            out_tag
);

	localparam int unsigned HI_W  = NUM_W - QUO_W;
	localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [QUO_W:0]                               vld_s;
	logic [QUO_W:0][LANES-1:0][DEN_W-1:0]         rem_s;
	logic [QUO_W:0][LANES-1:0][QUO_W-1:0]         lq_s;
	logic [QUO_W:0][LANES-1:0]                    ovf_s;
	logic [QUO_W:0][DEN_W-1:0]                    den_s;
	logic [QUO_W:0][TAG_W-1:0]                    tag_s;

	logic [LANES-1:0][CMP_W-1:0]                  hi_ext;
	logic [LANES-1:0]                             ovf0;
	logic [QUO_W-1:0][LANES-1:0][DEN_W:0]         trial;
	logic [QUO_W-1:0][LANES-1:0][DEN_W:0]         diff;
	logic [QUO_W-1:0][LANES-1:0]                  ge;

	// quotient overflow precheck on the upper numerator bits
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			hi_ext[l] = CMP_W'(in_num[l][NUM_W-1:QUO_W]);
			ovf0[l]   = hi_ext[l] >= CMP_W'(in_den);
		end
	end

	// one restoring step per stage
	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			for (int l = 0; l < LANES; l++) begin
				trial[k][l] = {rem_s[k][l], lq_s[k][l][QUO_W-1]};
				diff[k][l]  = trial[k][l] - {1'b0, den_s[k]};
				ge[k][l]    = trial[k][l] >= {1'b0, den_s[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[QUO_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= hi_ext[l][DEN_W-1:0];
				lq_s[0][l]  <= in_num[l][QUO_W-1:0];
			end
			ovf_s[0] <= ovf0;
			den_s[0] <= in_den;
			tag_s[0] <= in_tag;
			for (int k = 0; k < QUO_W; k++) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= ge[k][l] ? diff[k][l][DEN_W-1:0] :
						trial[k][l][DEN_W-1:0];
					lq_s[k+1][l]  <= {lq_s[k][l][QUO_W-2:0], ge[k][l]};
				end
				ovf_s[k+1] <= ovf_s[k];
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = lq_s[QUO_W];
	assign out_ovf   = ovf_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

// ===== src/off_axis_portal_frustum_top.sv =====
// ---------------------------------------------------------------------------
// off_axis_portal_frustum_top
// off-axis frustum tangents through a posed rectangular portal per eye point
// ---------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: eye_x, eye_y, eye_z
// m_*       out  m_tvalid/m_tready   m_tuser: valid_res; m_tdata: four tangents
// cfg_*     in   cfg_we              cfg_idx register index, cfg_wdata value
//
// one eye point per cycle sustained unless a config write or a stall holds
// the input; the path has two 33-stage bit-per-stage dividers (eye rotation
// and tangent quotients); a config write holds s_tready low while the matrix
// settles, and after reset s_tready rises once the settle counter expires
// a stall on m_tready freezes the pipeline once a result lands in the skid
// entry; the output register plus one skid entry keep the result in flight
// ---------------------------------------------------------------------------
`include "off_axis_portal_frustum_top_assert.svh"

module off_axis_portal_frustum_top import ofpf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [3*COORD_W-1:0]   s_tdata,   // eye_x, eye_y, eye_z
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [4*COORD_W-1:0]   m_tdata,   // tan_left, tan_right, tan_bottom, tan_top
	output logic                   m_tuser,   // valid_res
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	cfg_view_t view;
	logic      settled;
	logic      ce;

	logic                  rot_vld;
	logic [2:0][ACC_W-1:0] rot_mag;
	logic [2:0]            rot_neg;
	logic                  rot_ok;

	logic                    ed_vld;
	logic [2:0][QUO_W-1:0]   ed_quo;
	logic [2:0]              ed_ovf;
	logic [3:0]              ed_tag;

	logic [2:0][COORD_W-1:0] e_val;
	logic [2:0]              e_fit;
	logic                    vld_s1, ok_s1;
	logic [2:0][COORD_W-1:0] e_s1;

	logic signed [TSUM_W-1:0]  sw, sh, ex2, ey2;
	logic [3:0][TSUM_W-1:0]    tsum;
	logic                      vld_s2, ok_s2;
	logic [3:0][TNUM_W-1:0]    tnum_s2;
	logic [TDEN_W-1:0]         den_s2;

	logic                      vld_s3, ok_s3;
	logic [3:0][TNUM_W-1:0]    tmag_s3;
	logic [3:0]                tneg_s3;
	logic [TDEN_W-1:0]         den_s3;

	logic                    td_vld;
	logic [3:0][QUO_W-1:0]   td_quo;
	logic [3:0]              td_ovf;
	logic [4:0]              td_tag;

	logic [3:0][COORD_W-1:0] t_val;
	logic [3:0]              t_fit;
	logic                    vld_s4, ok_s4;
	logic [3:0][COORD_W-1:0] tan_s4;

	logic                    fin_res;
	logic [3:0][COORD_W-1:0] fin_tan;

	logic                    out_vld_q, out_res_q, skid_vld_q, skid_res_q;
	logic [3:0][COORD_W-1:0] out_tan_q, skid_tan_q;

	ofpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.view      (view),
		.settled   (settled)
	);

	// pipeline advances unless the skid entry is occupied
	assign ce       = !skid_vld_q;
	assign s_tready = settled && !skid_vld_q;

	ofpf_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_tvalid && s_tready),
		.eye       (s_tdata),
		.view      (view),
		.out_valid (rot_vld),
		.out_mag   (rot_mag),
		.out_neg   (rot_neg),
		.out_ok    (rot_ok)
	);

	// eye in portal space: row sums over the norm
	ofpf_div #(
		.LANES (3),
		.NUM_W (ACC_W),
		.DEN_W (N28_W),
		.TAG_W (4)
	) u_ediv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (rot_vld),
		.in_num    (rot_mag),
		.in_den    (view.n28),
		.in_tag    ({rot_ok, rot_neg}),
		.out_valid (ed_vld),
		.out_quo   (ed_quo),
		.out_ovf   (ed_ovf),
		.out_tag   (ed_tag)
	);

	// signed eye components, range and depth checks
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			e_val[l] = quo_apply(ed_quo[l], ed_tag[l]);
			e_fit[l] = quo_fits(ed_quo[l], ed_tag[l], ed_ovf[l]);
		end
	end

	// tangent numerators and depth denominator
	always_comb begin
		sw  = TSUM_W'(view.wsz);
		sh  = TSUM_W'(view.hsz);
		ex2 = TSUM_W'($signed(e_s1[0])) <<< 1;
		ey2 = TSUM_W'($signed(e_s1[1])) <<< 1;
		tsum[0] = -sw - ex2;
		tsum[1] = sw - ex2;
		tsum[2] = -sh - ey2;
		tsum[3] = sh - ey2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= ed_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= td_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			e_s1  <= e_val;
			ok_s1 <= ed_tag[3] && (&e_fit) && ($signed(e_val[2]) >= DEPTH_MIN);
			for (int l = 0; l < 4; l++) begin
				tnum_s2[l] <= {tsum[l], FRAC_W'(0)};
			end
			den_s2 <= {e_s1[2], 1'b0};
			ok_s2  <= ok_s1;
			for (int l = 0; l < 4; l++) begin
				tneg_s3[l] <= tnum_s2[l][TNUM_W-1];
				tmag_s3[l] <= tnum_s2[l][TNUM_W-1] ? -tnum_s2[l] : tnum_s2[l];
			end
			den_s3 <= den_s2;
			ok_s3  <= ok_s2;
			tan_s4 <= t_val;
			ok_s4  <= td_tag[4] && (&t_fit);
		end
	end

	// four tangent quotients over twice the depth
	ofpf_div #(
		.LANES (4),
		.NUM_W (TNUM_W),
		.DEN_W (TDEN_W),
		.TAG_W (5)
	) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s3),
		.in_num    (tmag_s3),
		.in_den    (den_s3),
		.in_tag    ({ok_s3, tneg_s3}),
		.out_valid (td_vld),
		.out_quo   (td_quo),
		.out_ovf   (td_ovf),
		.out_tag   (td_tag)
	);

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			t_val[l] = quo_apply(td_quo[l], td_tag[l]);
			t_fit[l] = quo_fits(td_quo[l], td_tag[l], td_ovf[l]);
		end
	end

	// ordering check, invalid results carry zero tangents
	always_comb begin
		fin_res = ok_s4 && ($signed(tan_s4[0]) < $signed(tan_s4[1])) &&
			($signed(tan_s4[2]) < $signed(tan_s4[3]));
		fin_tan = fin_res ? tan_s4 : '0;
	end

	// output register and skid entry, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			if (!out_vld_q || m_tready) begin
				out_vld_q <= vld_s4;
			end else if (vld_s4) begin
				skid_vld_q <= 1'b1;
			end
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	// output register and skid entry, data
	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			if (!out_vld_q || m_tready) begin
				out_res_q <= fin_res;
				out_tan_q <= fin_tan;
			end else begin
				skid_res_q <= fin_res;
				skid_tan_q <= fin_tan;
			end
		end else if (m_tready) begin
			out_res_q <= skid_res_q;
			out_tan_q <= skid_tan_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_res_q;
	assign m_tdata  = out_tan_q;

	`OFPF_ASSERT_NEXT(a_cfg_holds_input, cfg_we, !s_tready, "input taken right after a config write")
	`OFPF_ASSERT_IMPL(a_skid_needs_out, skid_vld_q, out_vld_q, "skid entry held with empty output")
	`OFPF_ASSERT_IMPL(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0, "invalid result carries data")
	`OFPF_ASSERT_IMPL(a_valid_ordered, m_tvalid && m_tuser, ($signed(m_tdata[31:0]) < $signed(m_tdata[63:32])) && ($signed(m_tdata[95:64]) < $signed(m_tdata[127:96])), "valid result with unordered tangents")

endmodule

// ===== tb/sv/tb_off_axis_portal_frustum_top.sv =====
// ---------------------------------------------------------------------------
// tb_off_axis_portal_frustum_top
// self-checking bench for the portal frustum block: eye points are streamed in
// under several portal poses and sizes, and each result is compared field by
// field with a bit-exact fixed-point frustum calculation kept in the bench
// ---------------------------------------------------------------------------
module tb_off_axis_portal_frustum_top;
	import ofpf_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic                      ok;
		logic signed [COORD_W-1:0] tl;
		logic signed [COORD_W-1:0] tr;
		logic signed [COORD_W-1:0] tb;
		logic signed [COORD_W-1:0] tt;
	} frustum_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               typed;
		frustum_t           want;
	} eye_row_t;

	localparam wide_t I32_LO = -(128'sd2147483648);
	localparam wide_t I32_HI = 128'sd2147483647;
	localparam int    N_DIR  = 12;
	localparam int    N_PHASE = 18;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [3*COORD_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [4*COORD_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]      cfg_wdata;

	// portal configuration as the bench believes it
	logic signed [COORD_W-1:0] pose_pos [3];
	logic signed [COORD_W-1:0] pose_quat [4];   // x, y, z, w
	logic [CFG_W-1:0]          portal_dim;

	frustum_t pending [$];
	int       fail_cnt;
	bit       calm;
	bit       hold_go;
	int       hold_left;

	off_axis_portal_frustum_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// clock and reset
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic fits32(input wide_t v);
		fits32 = v >= I32_LO && v <= I32_HI;
	endfunction

	function automatic wide_t mul28(input wide_t a, input wide_t b);
		mul28 = (a * b) >>> 32;
	endfunction

	// bit-exact frustum for one eye point under the current portal
	function automatic frustum_t portal_frustum(input logic [COORD_W-1:0] ux,
		input logic [COORD_W-1:0] uy, input logic [COORD_W-1:0] uz);
		wide_t qx, qy, qz, qw, n2, dev, n28, wsz, hsz;
		wide_t xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
		wide_t dx, dy, dz, ex, ey, ez, den, tl, tr, tb, tt;
		frustum_t f;
		f = '0;
		qx = pose_quat[0]; qy = pose_quat[1]; qz = pose_quat[2]; qw = pose_quat[3];
		wsz = portal_dim[SIZE_W-1:0];
		hsz = portal_dim[CFG_W-1:SIZE_W];
		n2 = ((qx * qx) >>> 4) + ((qy * qy) >>> 4) + ((qz * qz) >>> 4) + ((qw * qw) >>> 4);
		dev = n2 - wide_t'(NORM_ONE);
		if (dev < 0)
			dev = -dev;
		if (dev > wide_t'(NORM_TOL) || wsz == 0 || hsz == 0)
			return f;
		xx = mul28(qx, qx); yy = mul28(qy, qy); zz = mul28(qz, qz); ww = mul28(qw, qw);
		xy = mul28(qx, qy); xz = mul28(qx, qz); yz = mul28(qy, qz);
		wx = mul28(qw, qx); wy = mul28(qw, qy); wz = mul28(qw, qz);
		dx = wide_t'($signed(ux)) - wide_t'(pose_pos[0]);
		dy = wide_t'($signed(uy)) - wide_t'(pose_pos[1]);
		dz = wide_t'($signed(uz)) - wide_t'(pose_pos[2]);
		n28 = n2 >>> 28;
		// inverse rotation: transposed matrix times the offset
		ex = ((ww + xx - yy - zz) * dx + ((xy + wz) <<< 1) * dy + ((xz - wy) <<< 1) * dz) / n28;
		ey = (((xy - wz) <<< 1) * dx + (ww - xx + yy - zz) * dy + ((yz + wx) <<< 1) * dz) / n28;
		ez = (((xz + wy) <<< 1) * dx + ((yz - wx) <<< 1) * dy + (ww - xx - yy + zz) * dz) / n28;
		if (!fits32(ex) || !fits32(ey) || !fits32(ez) || ez < wide_t'(DEPTH_MIN))
			return f;
		den = ez <<< 1;
		tl = ((-wsz - (ex <<< 1)) <<< 16) / den;
		tr = ((wsz - (ex <<< 1)) <<< 16) / den;
		tb = ((-hsz - (ey <<< 1)) <<< 16) / den;
		tt = ((hsz - (ey <<< 1)) <<< 16) / den;
		if (!fits32(tl) || !fits32(tr) || !fits32(tb) || !fits32(tt))
			return f;
		if (tl >= tr || tb >= tt)
			return f;
		f.ok = 1;
		f.tl = tl[31:0]; f.tr = tr[31:0]; f.tb = tb[31:0]; f.tt = tt[31:0];
		return f;
	endfunction

	// one eye point; the expectation is either typed or predicted
	task automatic send_eye(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z, input logic typed, input frustum_t want);
		s_tdata  <= {z, y, x};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending.push_back(typed ? want : portal_frustum(x, y, z));
		if (!calm && $urandom_range(99) < 34) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// write all registers back to back from the bench copy
	task automatic write_regs();
		cfg_reg_t r;
		for (int i = 0; i < 8; i++) begin
			r = cfg_reg_t'(i);
			cfg_we  <= 1;
			cfg_idx <= r;
			case (r)
				REG_POS_X, REG_POS_Y, REG_POS_Z: begin
					cfg_wdata <= {{(CFG_W-COORD_W){1'b0}}, pose_pos[i]};
				end
				REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z, REG_QUAT_W: begin
					cfg_wdata <= {{(CFG_W-COORD_W){1'b0}}, pose_quat[i-3]};
				end
				default: begin
					cfg_wdata <= portal_dim;
				end
			endcase
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	// random unit quaternion, optionally scaled off unit length
	task automatic pick_quat(input real scale);
		real a [4];
		real n;
		n = 0.0;
		while (n < 1.0) begin
			n = 0.0;
			for (int i = 0; i < 4; i++) begin
				a[i] = $itor($urandom_range(2000)) - 1000.0;
				n += a[i] * a[i];
			end
		end
		n = $sqrt(n);
		for (int i = 0; i < 4; i++)
			pose_quat[i] = $rtoi(a[i] / n * scale * 1073741824.0);
	endtask

	// eye placed near the portal, mostly in front of it: local offset rotated into world
	task automatic framed_eye(output logic [COORD_W-1:0] ex, output logic [COORD_W-1:0] ey,
		output logic [COORD_W-1:0] ez);
		real v [3];
		real u [3];
		real c [3];
		real c2 [3];
		real w;
		v[0] = ($itor($urandom_range(200000)) - 100000.0) / 25000.0;
		v[1] = ($itor($urandom_range(200000)) - 100000.0) / 25000.0;
		v[2] = ($itor($urandom_range(160000)) - 5000.0) / 20000.0;
		for (int i = 0; i < 3; i++)
			u[i] = $itor(pose_quat[i]) / 1073741824.0;
		w = $itor(pose_quat[3]) / 1073741824.0;
		c[0] = u[1] * v[2] - u[2] * v[1];
		c[1] = u[2] * v[0] - u[0] * v[2];
		c[2] = u[0] * v[1] - u[1] * v[0];
		c2[0] = u[1] * c[2] - u[2] * c[1];
		c2[1] = u[2] * c[0] - u[0] * c[2];
		c2[2] = u[0] * c[1] - u[1] * c[0];
		ex = pose_pos[0] + $rtoi((v[0] + 2.0 * w * c[0] + 2.0 * c2[0]) * 65536.0);
		ey = pose_pos[1] + $rtoi((v[1] + 2.0 * w * c[1] + 2.0 * c2[1]) * 65536.0);
		ez = pose_pos[2] + $rtoi((v[2] + 2.0 * w * c[2] + 2.0 * c2[2]) * 65536.0);
	endtask

	// portal setting of one random phase; the first ones hit the special cases
	task automatic pick_portal(input int ph);
		for (int i = 0; i < 3; i++)
			pose_pos[i] = $signed(32'($urandom_range(2097152))) - 32'sd1048576;
		pick_quat(1.0);
		portal_dim = {24'($urandom_range(1, 200000)), 24'($urandom_range(1, 200000))};
		case (ph)
			0: pose_quat = '{0, 0, 0, 0};
			1: pick_quat(1.0015);
			2: portal_dim[SIZE_W-1:0] = '0;
			3: portal_dim[CFG_W-1:SIZE_W] = '0;
			4: begin
				portal_dim = {24'd1, 24'd1};
				pose_pos = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
			end
			5: begin
				portal_dim = '1;
				pose_pos = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
			end
			6: pose_quat = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
			7: begin
				portal_dim = CFG_W'({$urandom, $urandom});
				for (int i = 0; i < 3; i++)
					pose_pos[i] = $urandom;
			end
			8: pose_quat = '{0, 0, 32'sd759250125, 32'sd759250125};
			9: pick_quat(0.9992);
			default: ;
		endcase
	endtask

	// directed rows under the reset portal (0.7 m square, identity pose)
	eye_row_t dir_tab [N_DIR] = '{
		'{32'd0, 32'd0, 32'd65536, 1'b1, '{1'b1, -32'sd22937, 32'sd22937, -32'sd22937, 32'sd22937}},
		'{32'd0, 32'd0, 32'd0, 1'b1, frustum_t'(0)},
		'{32'd0, 32'd0, -32'sd65536, 1'b1, frustum_t'(0)},
		'{32'd0, 32'd0, 32'd6553, 1'b1, frustum_t'(0)},
		'{32'd0, 32'd0, 32'd6554, 1'b0, frustum_t'(0)},
		'{32'h4000_0000, 32'd0, 32'd6554, 1'b0, frustum_t'(0)},
		'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, frustum_t'(0)},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, frustum_t'(0)},
		'{32'h8000_0000, 32'd0, 32'd65536, 1'b0, frustum_t'(0)},
		'{32'd0, 32'h7fff_ffff, 32'd65536, 1'b0, frustum_t'(0)},
		'{32'd32768, -32'sd32768, 32'd131072, 1'b0, frustum_t'(0)},
		// depth so far that both horizontal tangents round to zero
		'{32'd0, 32'd0, 32'h7fff_ffff, 1'b1, frustum_t'(0)}
	};

	// stimulus
	initial begin
		logic [COORD_W-1:0] x, y, z;
		s_tvalid  <= 0;
		s_tdata   <= '0;
		cfg_we    <= 0;
		cfg_idx   <= REG_POS_X;
		cfg_wdata <= '0;
		calm      = 0;
		hold_go   = 0;
		pose_pos  = '{0, 0, 0};
		pose_quat = '{0, 0, 0, 32'sh4000_0000};
		portal_dim = SIZE_RST;
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++)
			send_eye(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed,
				dir_tab[i].want);
		for (int ph = 0; ph < N_PHASE; ph++) begin
			wait_idle();
			pick_portal(ph);
			write_regs();
			calm = (ph == 11);
			for (int k = 0; k < 102; k++) begin
				if (ph == 13 && k == 5)
					hold_go = 1;
				if ($urandom_range(99) < 80) begin
					framed_eye(x, y, z);
				end else begin
					x = $urandom; y = $urandom; z = $urandom;
				end
				send_eye(x, y, z, 1'b0, frustum_t'(0));
			end
		end
		wait_idle();
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver readiness, with one long hold-off on request
	initial begin
		m_tready <= 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go && hold_left == 0) begin
				hold_go = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else begin
				m_tready <= calm || $urandom_range(99) >= 34;
			end
		end
	end

	task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
		fail_cnt++;
	endtask

	// compare each accepted request against the oldest expectation
	initial begin
		frustum_t e;
		fail_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h", $time,
						m_tuser, m_tdata);
					fail_cnt++;
				end else begin
					e = pending.pop_front();
					if (m_tuser !== e.ok)
						report("valid_res", 32'(e.ok), 32'(m_tuser));
					if (m_tdata[31:0] !== e.tl)
						report("tan_left", e.tl, m_tdata[31:0]);
					if (m_tdata[63:32] !== e.tr)
						report("tan_right", e.tr, m_tdata[63:32]);
					if (m_tdata[95:64] !== e.tb)
						report("tan_bottom", e.tb, m_tdata[95:64]);
					if (m_tdata[127:96] !== e.tt)
						report("tan_top", e.tt, m_tdata[127:96]);
				end
			end
		end
	end

endmodule
